// File: src/rc4_pkg.sv
// Shared definitions for the RC4 stream cipher block: field structs, register
// indexes, reset values, request kinds and the sequencer state type.
// No dependencies.
package rc4_pkg;

   localparam int TABLE_SIZE            = 256;
   localparam int TABLE_ADDR_W          = 8;
   localparam logic [7:0] TABLE_LAST    = 8'(TABLE_SIZE - 1);

   localparam int MAX_KEY_BYTES_DEFAULT = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int KEY_LEN_W   = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH   = 2'd2;

   localparam logic [KEY_LEN_W-1:0]  KEY_LENGTH_RESET = 5'd5;
   localparam logic [CSR_DATA_W-1:0] KEY_LOW_RESET    = 64'h0000_006E_616E_6162;
   localparam logic [CSR_DATA_W-1:0] KEY_HIGH_RESET   = 64'h0;

   // Request kinds.
   localparam logic KIND_REKEY = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       packet_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // One access to the permutation memory per cycle: a read and a write.
   typedef struct packed {
      logic                    we;
      logic [TABLE_ADDR_W-1:0] waddr;
      logic [7:0]              wdata;
      logic [TABLE_ADDR_W-1:0] raddr;
   } sbox_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_DRD_J,
      ST_DSWAP_I,
      ST_DSWAP_J,
      ST_KINIT,
      ST_KRD,
      ST_KJ,
      ST_KW1,
      ST_KW2
   } state_type;

endpackage

// File: src/rc4_sbox.sv
// Permutation memory of the RC4 block: 256 bytes, one write port and one
// read port with registered read data (old data on a same-address write).
// Depends on rc4_pkg.
module rc4_sbox (
   input  logic                  clock,
   input  rc4_pkg::sbox_req_type mem_req,
   output logic [7:0]            rdata
);

   logic [7:0] table_mem [rc4_pkg::TABLE_SIZE];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         table_mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= table_mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/rc4_csr.sv
// Configuration registers of the RC4 block: key length and key bytes, with
// the clamped index of the last key byte used by the key schedule.
// Depends on rc4_pkg.
module rc4_csr #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEFAULT,
   localparam int KeyIdxW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [MAX_KEY_BYTES-1:0][7:0]      key_bytes,
   output logic [KeyIdxW-1:0]                 key_last
);

   logic [rc4_pkg::KEY_LEN_W-1:0] len_ff;
   logic [MAX_KEY_BYTES-1:0][7:0] key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= rc4_pkg::KEY_LENGTH_RESET;
         for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            key_ff[b] <= (b < 8) ? rc4_pkg::KEY_LOW_RESET[(b & 7) * 8 +: 8]
                                 : rc4_pkg::KEY_HIGH_RESET[(b & 7) * 8 +: 8];
         end
      end else if (csr_we) begin
         unique case (csr_index)
            rc4_pkg::CSR_KEY_LENGTH: begin
               len_ff <= csr_wdata[rc4_pkg::KEY_LEN_W-1:0];
            end
            rc4_pkg::CSR_KEY_LOW: begin
               for (int b = 0; b < MAX_KEY_BYTES; b++) begin
                  if (b < 8) key_ff[b] <= csr_wdata[(b & 7) * 8 +: 8];
               end
            end
            rc4_pkg::CSR_KEY_HIGH: begin
               for (int b = 0; b < MAX_KEY_BYTES; b++) begin
                  if (b >= 8) key_ff[b] <= csr_wdata[(b & 7) * 8 +: 8];
               end
            end
            default: ;
         endcase
      end
   end

   // A length of zero acts as one, and anything above the key storage
   // saturates to the full key.
   always_comb begin
      if (len_ff == '0) begin
         key_last = '0;
      end else if (len_ff > rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
         key_last = KeyIdxW'(MAX_KEY_BYTES - 1);
      end else begin
         key_last = KeyIdxW'(len_ff - 5'd1);
      end
   end

   assign key_bytes = key_ff;

endmodule

// File: src/rc4_core.sv
// Sequencer and datapath of the RC4 block: key schedule, keystream generation
// with read-modify-write of the permutation memory, and the result register.
// Depends on rc4_pkg.
module rc4_core #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEFAULT,
   localparam int KeyIdxW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rc4_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rc4_pkg::rsp_type              rsp_data,
   input  logic [MAX_KEY_BYTES-1:0][7:0] key_bytes,
   input  logic [KeyIdxW-1:0]            key_last,
   output rc4_pkg::sbox_req_type         mem_req,
   input  logic [7:0]                    mem_rdata
);

   rc4_pkg::state_type state_ff, state_in;

   logic [7:0]         i_ff, i_in;
   logic [7:0]         j_ff, j_in;
   logic [7:0]         n_ff, n_in;
   logic [KeyIdxW-1:0] kidx_ff, kidx_in;
   logic [7:0]         si_ff, si_in;
   logic [7:0]         sj_ff, sj_in;
   logic [7:0]         data_ff, data_in;
   logic               last_ff, last_in;
   logic               keyed_ff, keyed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rc4_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic       out_free;
   logic [7:0] j_next;
   logic [7:0] ks_addr;
   logic [7:0] ks_byte;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != rc4_pkg::ST_IDLE);

   // Keystream index from the swapped pair; the read data misses the swap
   // writes, so entries i and j are taken from the registered pair instead.
   assign ks_addr = 8'(si_ff + sj_ff);
   always_comb begin
      if (ks_addr == i_ff) begin
         ks_byte = sj_ff;
      end else if (ks_addr == j_ff) begin
         ks_byte = si_ff;
      end else begin
         ks_byte = mem_rdata;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.kind == rc4_pkg::KIND_REKEY) begin
                  state_in = rc4_pkg::ST_KINIT;
               end else if (keyed_ff) begin
                  state_in = rc4_pkg::ST_DRD_J;
               end else begin
                  state_in = rc4_pkg::ST_PASS;
               end
            end
         end
         rc4_pkg::ST_PASS: begin
            if (out_free) state_in = rc4_pkg::ST_IDLE;
         end
         rc4_pkg::ST_DRD_J:   state_in = rc4_pkg::ST_DSWAP_I;
         rc4_pkg::ST_DSWAP_I: state_in = rc4_pkg::ST_DSWAP_J;
         rc4_pkg::ST_DSWAP_J: begin
            if (out_free) state_in = rc4_pkg::ST_IDLE;
         end
         rc4_pkg::ST_KINIT: begin
            if (n_ff == rc4_pkg::TABLE_LAST) state_in = rc4_pkg::ST_KRD;
         end
         rc4_pkg::ST_KRD: state_in = rc4_pkg::ST_KJ;
         rc4_pkg::ST_KJ:  state_in = rc4_pkg::ST_KW1;
         rc4_pkg::ST_KW1: state_in = rc4_pkg::ST_KW2;
         rc4_pkg::ST_KW2: begin
            if (n_ff == rc4_pkg::TABLE_LAST) begin
               state_in = rc4_pkg::ST_IDLE;
            end else begin
               state_in = rc4_pkg::ST_KRD;
            end
         end
         default: state_in = rc4_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory accesses.
   always_comb begin
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      kidx_in      = kidx_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      keyed_in     = keyed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      j_next       = j_ff;
      mem_req      = '{we: 1'b0, waddr: i_ff, wdata: si_ff, raddr: 8'(i_ff + 8'd1)};

      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (req_valid) begin
               data_in = req_data.data_byte;
               last_in = req_data.packet_last;
               n_in    = '0;
               if (req_data.kind == rc4_pkg::KIND_DATA && keyed_ff) begin
                  i_in = 8'(i_ff + 8'd1);
               end
            end
         end
         rc4_pkg::ST_PASS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: data_ff, out_last: last_ff};
            end
         end
         rc4_pkg::ST_DRD_J: begin
            j_next        = 8'(j_ff + mem_rdata);
            mem_req.raddr = j_next;
            si_in         = mem_rdata;
            j_in          = j_next;
         end
         rc4_pkg::ST_DSWAP_I: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = i_ff;
            mem_req.wdata = mem_rdata;
            mem_req.raddr = 8'(si_ff + mem_rdata);
            sj_in         = mem_rdata;
         end
         rc4_pkg::ST_DSWAP_J: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = j_ff;
            mem_req.wdata = si_ff;
            mem_req.raddr = ks_addr;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: data_ff ^ ks_byte, out_last: last_ff};
            end
         end
         rc4_pkg::ST_KINIT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = n_ff;
            mem_req.wdata = n_ff;
            n_in          = 8'(n_ff + 8'd1);
            j_in          = '0;
            kidx_in       = '0;
         end
         rc4_pkg::ST_KRD: begin
            mem_req.raddr = n_ff;
         end
         rc4_pkg::ST_KJ: begin
            j_next        = 8'(j_ff + mem_rdata + key_bytes[kidx_ff]);
            mem_req.raddr = j_next;
            si_in         = mem_rdata;
            j_in          = j_next;
         end
         rc4_pkg::ST_KW1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = n_ff;
            mem_req.wdata = mem_rdata;
         end
         rc4_pkg::ST_KW2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = j_ff;
            mem_req.wdata = si_ff;
            n_in          = 8'(n_ff + 8'd1);
            kidx_in       = (kidx_ff == key_last) ? '0 : KeyIdxW'(kidx_ff + 1'b1);
            if (n_ff == rc4_pkg::TABLE_LAST) begin
               keyed_in = 1'b1;
               i_in     = '0;
               j_in     = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc4_pkg::ST_IDLE;
         keyed_ff     <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         keyed_ff     <= keyed_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      kidx_ff     <= kidx_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher block: configuration registers,
// sequencer and permutation memory.
// Depends on rc4_pkg, rc4_csr, rc4_core and rc4_sbox.
//
//   Channel   Ports                               Direction  Moves
//   request   req_valid, req_stall, req_data      in         rekey or data byte
//   response  rsp_valid, rsp_stall, rsp_data      out        transformed byte
//   config    csr_we, csr_index, csr_wdata        in         register write
//
// A keyed data byte reads entries i and j, then swaps them; an unkeyed byte
// passes through unchanged. Either waits while the response register is stalled,
// and no new request is taken until it ends. A rekey fills all 256 entries with
// the identity, then runs 256 key schedule steps. Both follow from the single
// read port of the permutation memory and its registered read data.
// Reset is synchronous and active high; it clears the sequencer, the indices i and j,
// the keyed flag and the response register, and loads the register defaults.
// The response register holds a finished byte while rsp_stall is high; the
// block stops only at the point of loading it.
module rc4_stream_cipher #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rc4_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rc4_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int KeyIdxW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   logic [MAX_KEY_BYTES-1:0][7:0] key_bytes;
   logic [KeyIdxW-1:0]            key_last;
   rc4_pkg::sbox_req_type         mem_req;
   logic [7:0]                    mem_rdata;

   // Key registers. The key schedule reads them only while a rekey runs; they must be
   // written only while the block is idle, which the block itself does not enforce.
   rc4_csr #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .key_bytes(key_bytes),
      .key_last (key_last)
   );

   // Sequencer. Every table access goes through the memory request struct;
   // the swap writes of one request finish before the next request reads.
   rc4_core #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .key_bytes(key_bytes),
      .key_last (key_last),
      .mem_req  (mem_req),
      .mem_rdata(mem_rdata)
   );

   // The permutation itself. Its contents matter only once a rekey has
   // filled it, so it needs no reset.
   rc4_sbox u_sbox (
      .clock  (clock),
      .mem_req(mem_req),
      .rdata  (mem_rdata)
   );

endmodule

// File: src/rc4_checker.sv
// Port-level checks for the RC4 stream cipher block, bound to the top level.
// Depends on rc4_pkg and rc4_stream_cipher.
module rc4_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input rc4_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rc4_pkg::rsp_type rsp_data
);

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another was in progress");

   // A rekey accepted while no response is waiting does not make one appear.
   a_rekey_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.kind == rc4_pkg::KIND_REKEY && !rsp_valid)
      |=> !rsp_valid)
      else $error("response appeared after a rekey");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind rc4_stream_cipher rc4_checker u_checker (.*);
